// ===== rtl/core/lqe_pkg.sv =====
// Shared types and constants for the line to quad expansion block.
// No dependencies; imported by line_to_quad_expand_unit.
package lqe_pkg;

    // Number of root bits and quotient bits produced one per stage
    localparam int SQRT_STEPS = 31;
    localparam int DIV_STEPS  = 32;

    // Magnitude limit for the shrunk direction and normal components
    localparam logic [32:0] MAG_LIMIT = 33'h0_4000_0000;

    // Vertex order codes: bit 0 selects end, bit 1 selects the minus side
    localparam logic [1:0] VTX_START_PLUS  = 2'd0;
    localparam logic [1:0] VTX_END_MINUS   = 2'd3;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        logic [31:0] ex;
        logic [31:0] ey;
        logic [31:0] ez;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic [31:0] dif;
        logic [31:0] spe;
    } pass_t;

    typedef struct packed {
        pass_t       p;
        logic [30:0] w;
        logic [2:0]  neg;
        logic        zero;
    } carry_t;

    // Shift three signed magnitudes right together until all are <= 2^30
    function automatic logic [2:0][31:0] shrink3(input logic [2:0][32:0] v);
        logic [2:0][32:0] m;
        logic [2:0][32:0] sh;
        logic             big1;
        logic             big2;
        logic [2:0][31:0] r;
        big1 = 1'b0;
        big2 = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = v[i][32] ? 33'(-v[i]) : v[i];
            if (m[i] > MAG_LIMIT)
                big1 = 1'b1;
            if ((m[i] >> 1) > MAG_LIMIT)
                big2 = 1'b1;
        end
        for (int i = 0; i < 3; i++)
        begin
            sh[i] = big2 ? (m[i] >> 2) : (big1 ? (m[i] >> 1) : m[i]);
            r[i]  = v[i][32] ? 32'(-sh[i]) : sh[i][31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/line_to_quad_expand_unit.sv =====
// Line segment to quad expansion: side vector from cross product, four vertices.
// Depends on lqe_pkg (types, shrink function, vertex codes).
// Throughput: one request per quad of four vertices, set by the four-vertex output sequencer;
// the 75-stage arithmetic pipeline itself takes one request per cycle while it is not stalled.
// Reset: rst_n clears all valid bits and the sequencer; payload is not reset.
module line_to_quad_expand_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] start_x,
    input  logic [31:0] start_y,
    input  logic [31:0] start_z,
    input  logic [31:0] end_x,
    input  logic [31:0] end_y,
    input  logic [31:0] end_z,
    input  logic [31:0] norm_x,
    input  logic [31:0] norm_y,
    input  logic [31:0] norm_z,
    input  logic [30:0] line_width,
    input  logic [31:0] diffuse_color,
    input  logic [31:0] specular_color,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [31:0] pos_z,
    output logic [31:0] out_norm_x,
    output logic [31:0] out_norm_y,
    output logic [31:0] out_norm_z,
    output logic [31:0] out_diffuse,
    output logic [31:0] out_specular,
    output logic        tex_u,
    output logic        tex_v,
    output logic        last_vertex
);
    import lqe_pkg::*;

    logic adv;
    logic seq_take;

    // Stage 1: differences
    logic             s1_v_reg;
    carry_t           s1_car_reg;
    logic [2:0][32:0] s1_d_reg;
    // Stage 2: shrunk direction and normal
    logic             s2_v_reg;
    carry_t           s2_car_reg;
    logic [2:0][31:0] s2_d_reg;
    logic [2:0][31:0] s2_n_reg;
    // Stage 3: six cross products
    logic             s3_v_reg;
    carry_t           s3_car_reg;
    logic [5:0][63:0] s3_pr_reg;
    // Stage 4 and normalize stages
    logic             na_v_reg   [0:3];
    carry_t           na_car_reg [0:3];
    logic [2:0][61:0] na_a_reg   [0:3];
    // Squares
    logic             s8_v_reg;
    carry_t           s8_car_reg;
    logic [2:0][29:0] s8_an_reg;
    logic [2:0][59:0] s8_sq_reg;
    // Square root stages
    logic             sq_v_reg    [0:SQRT_STEPS];
    carry_t           sq_car_reg  [0:SQRT_STEPS];
    logic [2:0][29:0] sq_an_reg   [0:SQRT_STEPS];
    logic [61:0]      sq_rem_reg  [0:SQRT_STEPS];
    logic [30:0]      sq_root_reg [0:SQRT_STEPS];
    // Numerator products
    logic             m_v_reg;
    carry_t           m_car_reg;
    logic [2:0][60:0] m_prod_reg;
    logic [30:0]      m_len_reg;
    // Divider stages
    logic             dv_v_reg   [0:DIV_STEPS];
    carry_t           dv_car_reg [0:DIV_STEPS];
    logic [31:0]      dv_div_reg [0:DIV_STEPS];
    logic [2:0][61:0] dv_rem_reg [0:DIV_STEPS];
    logic [2:0][31:0] dv_q_reg   [0:DIV_STEPS];
    // Final side vector
    logic             f_v_reg;
    carry_t           f_car_reg;
    logic [2:0][31:0] f_side_reg;
    // Output sequencer
    logic             out_valid_reg;
    logic [1:0]       seq_k_reg;
    logic [1:0]       seq_k_next;
    pass_t            seq_p_reg;
    logic [2:0][31:0] seq_side_reg;

    // Advance the whole pipeline unless the last stage is blocked
    assign seq_take = !out_valid_reg || (out_ready && (seq_k_reg == VTX_END_MINUS));
    assign adv      = !(f_v_reg && !seq_take);
    assign in_ready = adv;

    // Stage 1: capture request and form exact differences
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_car_reg  <= '{'{start_x, start_y, start_z, end_x, end_y, end_z,
                               norm_x, norm_y, norm_z, diffuse_color, specular_color},
                             line_width, 3'b000, 1'b0};
            s1_d_reg[0] <= 33'($signed(end_x)) - 33'($signed(start_x));
            s1_d_reg[1] <= 33'($signed(end_y)) - 33'($signed(start_y));
            s1_d_reg[2] <= 33'($signed(end_z)) - 33'($signed(start_z));
        end
    end

    // Stage 2: shrink direction and normal into range
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_car_reg <= s1_car_reg;
            s2_d_reg   <= shrink3(s1_d_reg);
            s2_n_reg   <= shrink3({33'($signed(s1_car_reg.p.nz)),
                                   33'($signed(s1_car_reg.p.ny)),
                                   33'($signed(s1_car_reg.p.nx))});
        end
    end

    // Stage 3: cross product terms
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_car_reg   <= s2_car_reg;
            s3_pr_reg[0] <= 64'($signed(s2_d_reg[1]) * $signed(s2_n_reg[2]));
            s3_pr_reg[1] <= 64'($signed(s2_d_reg[2]) * $signed(s2_n_reg[1]));
            s3_pr_reg[2] <= 64'($signed(s2_d_reg[2]) * $signed(s2_n_reg[0]));
            s3_pr_reg[3] <= 64'($signed(s2_d_reg[0]) * $signed(s2_n_reg[2]));
            s3_pr_reg[4] <= 64'($signed(s2_d_reg[0]) * $signed(s2_n_reg[1]));
            s3_pr_reg[5] <= 64'($signed(s2_d_reg[1]) * $signed(s2_n_reg[0]));
        end
    end

    // Stage 4: cross product, split into magnitude and sign
    always_ff @(posedge clk)
    begin
        logic [63:0] c;
        carry_t      car;
        if (adv)
        begin
            car = s3_car_reg;
            for (int i = 0; i < 3; i++)
            begin
                c = s3_pr_reg[2*i] - s3_pr_reg[2*i+1];
                car.neg[i]     = c[63];
                na_a_reg[0][i] <= c[63] ? 62'(-c) : c[61:0];
            end
            na_car_reg[0] <= car;
        end
    end

    // Normalize: left-align the common top bit, two shift steps per stage
    for (genvar g = 0; g < 3; g++)
    begin : g_norm
        localparam int K1 = 32 >> (2 * g);
        localparam int K2 = K1 / 2;
        always_ff @(posedge clk)
        begin
            logic [2:0][61:0] a;
            logic [61:0]      o;
            if (adv)
            begin
                a = na_a_reg[g];
                o = a[0] | a[1] | a[2];
                if ((o >> (62 - K1)) == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        a[i] = a[i] << K1;
                end
                o = a[0] | a[1] | a[2];
                if ((o >> (62 - K2)) == '0)
                begin
                    for (int i = 0; i < 3; i++)
                        a[i] = a[i] << K2;
                end
                na_a_reg[g+1]   <= a;
                na_car_reg[g+1] <= na_car_reg[g];
            end
        end
    end

    // Squares of the normalized magnitudes (top bit now at bit 29)
    always_ff @(posedge clk)
    begin
        carry_t car;
        if (adv)
        begin
            car      = na_car_reg[3];
            car.zero = (na_a_reg[3][0] | na_a_reg[3][1] | na_a_reg[3][2]) == '0;
            s8_car_reg <= car;
            for (int i = 0; i < 3; i++)
            begin
                s8_an_reg[i] <= na_a_reg[3][i][61:32];
                s8_sq_reg[i] <= na_a_reg[3][i][61:32] * na_a_reg[3][i][61:32];
            end
        end
    end

    // Sum of squares feeds the root
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_car_reg[0]  <= s8_car_reg;
            sq_an_reg[0]   <= s8_an_reg;
            sq_rem_reg[0]  <= 62'(s8_sq_reg[0]) + 62'(s8_sq_reg[1]) + 62'(s8_sq_reg[2]);
            sq_root_reg[0] <= '0;
        end
    end

    // Integer square root, one root bit per stage
    for (genvar g = 0; g < SQRT_STEPS; g++)
    begin : g_sqrt
        localparam int B = SQRT_STEPS - 1 - g;
        always_ff @(posedge clk)
        begin
            logic [62:0] trial;
            if (adv)
            begin
                trial = (63'(sq_root_reg[g]) << (B + 1)) | (63'(1) << (2 * B));
                if ({1'b0, sq_rem_reg[g]} >= trial)
                begin
                    sq_rem_reg[g+1]  <= 62'({1'b0, sq_rem_reg[g]} - trial);
                    sq_root_reg[g+1] <= sq_root_reg[g] | (31'(1) << B);
                end
                else
                begin
                    sq_rem_reg[g+1]  <= sq_rem_reg[g];
                    sq_root_reg[g+1] <= sq_root_reg[g];
                end
                sq_car_reg[g+1] <= sq_car_reg[g];
                sq_an_reg[g+1]  <= sq_an_reg[g];
            end
        end
    end

    // Scale magnitudes by the width
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_car_reg <= sq_car_reg[SQRT_STEPS];
            m_len_reg <= sq_root_reg[SQRT_STEPS];
            for (int i = 0; i < 3; i++)
                m_prod_reg[i] <= sq_an_reg[SQRT_STEPS][i] * sq_car_reg[SQRT_STEPS].w;
        end
    end

    // Add rounding term, set up divisor 2L
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_car_reg[0] <= m_car_reg;
            dv_div_reg[0] <= {m_len_reg, 1'b0};
            dv_q_reg[0]   <= '0;
            for (int i = 0; i < 3; i++)
                dv_rem_reg[0][i] <= 62'(m_prod_reg[i]) + 62'(m_len_reg);
        end
    end

    // Restoring division, one quotient bit per stage for all three lanes
    for (genvar g = 0; g < DIV_STEPS; g++)
    begin : g_div
        localparam int J = DIV_STEPS - 1 - g;
        always_ff @(posedge clk)
        begin
            logic [63:0] trial;
            if (adv)
            begin
                trial = 64'(dv_div_reg[g]) << J;
                for (int i = 0; i < 3; i++)
                begin
                    if ({2'b0, dv_rem_reg[g][i]} >= trial)
                    begin
                        dv_rem_reg[g+1][i] <= 62'({2'b0, dv_rem_reg[g][i]} - trial);
                        dv_q_reg[g+1][i]   <= dv_q_reg[g][i] | (32'(1) << J);
                    end
                    else
                    begin
                        dv_rem_reg[g+1][i] <= dv_rem_reg[g][i];
                        dv_q_reg[g+1][i]   <= dv_q_reg[g][i];
                    end
                end
                dv_car_reg[g+1] <= dv_car_reg[g];
                dv_div_reg[g+1] <= dv_div_reg[g];
            end
        end
    end

    // Apply sign, drop the side vector for a zero cross product
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_car_reg <= dv_car_reg[DIV_STEPS];
            for (int i = 0; i < 3; i++)
            begin
                if (dv_car_reg[DIV_STEPS].zero)
                    f_side_reg[i] <= '0;
                else if (dv_car_reg[DIV_STEPS].neg[i])
                    f_side_reg[i] <= 32'(0) - dv_q_reg[DIV_STEPS][i];
                else
                    f_side_reg[i] <= dv_q_reg[DIV_STEPS][i];
            end
        end
    end

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            for (int k = 0; k <= 3; k++)
                na_v_reg[k] <= 1'b0;
            s8_v_reg <= 1'b0;
            for (int k = 0; k <= SQRT_STEPS; k++)
                sq_v_reg[k] <= 1'b0;
            m_v_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++)
                dv_v_reg[k] <= 1'b0;
            f_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg    <= in_valid;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            na_v_reg[0] <= s3_v_reg;
            for (int k = 1; k <= 3; k++)
                na_v_reg[k] <= na_v_reg[k-1];
            s8_v_reg    <= na_v_reg[3];
            sq_v_reg[0] <= s8_v_reg;
            for (int k = 1; k <= SQRT_STEPS; k++)
                sq_v_reg[k] <= sq_v_reg[k-1];
            m_v_reg     <= sq_v_reg[SQRT_STEPS];
            dv_v_reg[0] <= m_v_reg;
            for (int k = 1; k <= DIV_STEPS; k++)
                dv_v_reg[k] <= dv_v_reg[k-1];
            f_v_reg     <= dv_v_reg[DIV_STEPS];
        end
    end

    // Sequencer: step through the four vertices of the held quad
    always_comb
    begin
        seq_k_next = seq_k_reg;
        if (out_valid_reg && out_ready)
            seq_k_next = seq_k_reg + 2'd1;
        if (seq_take && f_v_reg)
            seq_k_next = VTX_START_PLUS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seq_k_reg     <= VTX_START_PLUS;
        end
        else
        begin
            seq_k_reg <= seq_k_next;
            if (seq_take)
                out_valid_reg <= f_v_reg;
        end
    end

    // Load the next quad's data when the sequencer frees up
    always_ff @(posedge clk)
    begin
        if (seq_take && f_v_reg)
        begin
            seq_p_reg    <= f_car_reg.p;
            seq_side_reg <= f_side_reg;
        end
    end

    // Vertex position: start or end, plus or minus side
    assign pos_x = seq_k_reg[1] ? (seq_k_reg[0] ? seq_p_reg.ex : seq_p_reg.sx) - seq_side_reg[0]
                                : (seq_k_reg[0] ? seq_p_reg.ex : seq_p_reg.sx) + seq_side_reg[0];
    assign pos_y = seq_k_reg[1] ? (seq_k_reg[0] ? seq_p_reg.ey : seq_p_reg.sy) - seq_side_reg[1]
                                : (seq_k_reg[0] ? seq_p_reg.ey : seq_p_reg.sy) + seq_side_reg[1];
    assign pos_z = seq_k_reg[1] ? (seq_k_reg[0] ? seq_p_reg.ez : seq_p_reg.sz) - seq_side_reg[2]
                                : (seq_k_reg[0] ? seq_p_reg.ez : seq_p_reg.sz) + seq_side_reg[2];

    assign out_valid    = out_valid_reg;
    assign out_norm_x   = seq_p_reg.nx;
    assign out_norm_y   = seq_p_reg.ny;
    assign out_norm_z   = seq_p_reg.nz;
    assign out_diffuse  = seq_p_reg.dif;
    assign out_specular = seq_p_reg.spe;
    assign tex_u        = seq_k_reg[0];
    assign tex_v        = seq_k_reg[1];
    assign last_vertex  = (seq_k_reg == VTX_END_MINUS);

    // A blocked final stage keeps its request
    a_final_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (f_v_reg && !seq_take) |=> (f_v_reg && $stable(f_side_reg)))
        else $error("final stage dropped a blocked request");

    // A new quad is loaded only after the fourth vertex leaves
    a_quad_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !last_vertex) |=> (out_valid_reg && !$stable(seq_k_reg)))
        else $error("quad sequencer skipped or restarted early");

    // A zero side vector gives pos_x equal to the start point's x on the start vertices
    a_zero_side: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && seq_side_reg == '0 && !seq_k_reg[0]) |-> (pos_x == seq_p_reg.sx))
        else $error("position differs from start with zero side vector");

endmodule

// ===== tb/line_to_quad_expand_unit_checker.sv =====
// Checker for line_to_quad_expand_unit: watches both channels, predicts vertices.
// Depends on nothing but the block's port widths; no package types needed.
module line_to_quad_expand_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] start_x,
    input  logic [31:0] start_y,
    input  logic [31:0] start_z,
    input  logic [31:0] end_x,
    input  logic [31:0] end_y,
    input  logic [31:0] end_z,
    input  logic [31:0] norm_x,
    input  logic [31:0] norm_y,
    input  logic [31:0] norm_z,
    input  logic [30:0] line_width,
    input  logic [31:0] diffuse_color,
    input  logic [31:0] specular_color,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [31:0] out_norm_x,
    input  logic [31:0] out_norm_y,
    input  logic [31:0] out_norm_z,
    input  logic [31:0] out_diffuse,
    input  logic [31:0] out_specular,
    input  logic        tex_u,
    input  logic        tex_v,
    input  logic        last_vertex,
    output int          fail_count,
    output int          pending_vertices
);

    typedef struct {
        logic [31:0] px, py, pz, nx, ny, nz, dif, spe;
        logic        u, v, lst;
    } vertex_t;

    vertex_t vertex_queue[$];

    // Bring three magnitudes to at most 2^30 with one common right shift
    function automatic void shrink_vec(ref longint v[3]);
        longint unsigned a[3];
        longint unsigned m;
        int s;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = (v[i] < 0) ? -v[i] : v[i];
            if (a[i] > m)
                m = a[i];
        end
        while ((m >> s) > (64'd1 << 30))
            s++;
        for (int i = 0; i < 3; i++)
            v[i] = (v[i] < 0) ? -longint'(a[i] >> s) : longint'(a[i] >> s);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned q);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > q)
            b >>= 2;
        while (b != 0)
        begin
            if (q >= r + b)
            begin
                q -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Compute the side vector and queue the four quad corners
    task automatic predict_quad();
        longint st[3], en[3], d[3], n[3], c[3], side[3];
        longint unsigned a[3], m, q, len, w;
        vertex_t vx;
        st = '{longint'(signed'(start_x)), longint'(signed'(start_y)),
               longint'(signed'(start_z))};
        en = '{longint'(signed'(end_x)), longint'(signed'(end_y)),
               longint'(signed'(end_z))};
        n  = '{longint'(signed'(norm_x)), longint'(signed'(norm_y)),
               longint'(signed'(norm_z))};
        for (int i = 0; i < 3; i++)
            d[i] = en[i] - st[i];
        w = line_width;
        shrink_vec(d);
        shrink_vec(n);
        c[0] = d[1] * n[2] - d[2] * n[1];
        c[1] = d[2] * n[0] - d[0] * n[2];
        c[2] = d[0] * n[1] - d[1] * n[0];
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = (c[i] < 0) ? -c[i] : c[i];
            if (a[i] > m)
                m = a[i];
            side[i] = 0;
        end
        if (m != 0)
        begin
            while (m >= (64'd1 << 30))
            begin
                m >>= 1;
                for (int i = 0; i < 3; i++)
                    a[i] >>= 1;
            end
            while (m < (64'd1 << 29))
            begin
                m <<= 1;
                for (int i = 0; i < 3; i++)
                    a[i] <<= 1;
            end
            q = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
            len = floor_sqrt(q);
            for (int i = 0; i < 3; i++)
            begin
                side[i] = longint'((a[i] * w + len) / (2 * len));
                if (c[i] < 0)
                    side[i] = -side[i];
            end
        end
        for (int k = 0; k < 4; k++)
        begin
            logic [31:0] b[3];
            logic [31:0] s[3];
            logic [31:0] p[3];
            for (int i = 0; i < 3; i++)
            begin
                b[i] = k[0] ? en[i][31:0] : st[i][31:0];
                s[i] = side[i][31:0];
                p[i] = k[1] ? b[i] - s[i] : b[i] + s[i];
            end
            vx.px = p[0];
            vx.py = p[1];
            vx.pz = p[2];
            vx.nx = norm_x;
            vx.ny = norm_y;
            vx.nz = norm_z;
            vx.dif = diffuse_color;
            vx.spe = specular_color;
            vx.u = k[0];
            vx.v = k[1];
            vx.lst = (k == 3);
            vertex_queue.push_back(vx);
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    assign pending_vertices = vertex_queue.size();

    // Predict on accepted requests, compare accepted vertices
    always @(posedge clk)
    begin
        if (!rst_n)
            fail_count = 0;
        if (rst_n && in_valid && in_ready)
            predict_quad();
        if (rst_n && out_valid && out_ready)
        begin
            if (vertex_queue.size() == 0)
            begin
                $display("MISMATCH: vertex with nothing expected");
                fail_count++;
            end
            else
            begin
                vertex_t e;
                e = vertex_queue.pop_front();
                if (pos_x !== e.px) report_mismatch("pos_x", pos_x, e.px);
                if (pos_y !== e.py) report_mismatch("pos_y", pos_y, e.py);
                if (pos_z !== e.pz) report_mismatch("pos_z", pos_z, e.pz);
                if (out_norm_x !== e.nx) report_mismatch("out_norm_x", out_norm_x, e.nx);
                if (out_norm_y !== e.ny) report_mismatch("out_norm_y", out_norm_y, e.ny);
                if (out_norm_z !== e.nz) report_mismatch("out_norm_z", out_norm_z, e.nz);
                if (out_diffuse !== e.dif) report_mismatch("out_diffuse", out_diffuse, e.dif);
                if (out_specular !== e.spe)
                    report_mismatch("out_specular", out_specular, e.spe);
                if (tex_u !== e.u) report_mismatch("tex_u", tex_u, e.u);
                if (tex_v !== e.v) report_mismatch("tex_v", tex_v, e.v);
                if (last_vertex !== e.lst)
                    report_mismatch("last_vertex", last_vertex, e.lst);
            end
        end
    end

endmodule

// ===== tb/line_to_quad_expand_unit_tb.sv =====
// Testbench top for line_to_quad_expand_unit: directed and random segments.
// Depends on line_to_quad_expand_unit and line_to_quad_expand_unit_checker.
module line_to_quad_expand_unit_tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] start_x, start_y, start_z, end_x, end_y, end_z;
    logic [31:0] norm_x, norm_y, norm_z;
    logic [30:0] line_width;
    logic [31:0] diffuse_color, specular_color;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] pos_x, pos_y, pos_z, out_norm_x, out_norm_y, out_norm_z;
    logic [31:0] out_diffuse, out_specular;
    logic        tex_u, tex_v, last_vertex;
    int          fail_count;
    int          pending_vertices;
    bit          calm;

    line_to_quad_expand_unit u_dut (.*);
    line_to_quad_expand_unit_checker u_check (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Stall the result side at random, except in the calm stretch
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 24);

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7FFF_FFFF - $urandom_range(3);
            2: return 32'($signed($urandom_range(2000)) - 1000) <<< 12;
            default: return $urandom;
        endcase
    endfunction

    // Present one request and hold it until taken; idle before it at random
    task automatic send_segment(logic [31:0] sx, sy, sz, ex, ey, ez, nx, ny, nz,
                                logic [30:0] w, logic [31:0] dc, sc);
        while (!calm && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        start_x <= sx; start_y <= sy; start_z <= sz;
        end_x <= ex; end_y <= ey; end_z <= ez;
        norm_x <= nx; norm_y <= ny; norm_z <= nz;
        line_width <= w;
        diffuse_color <= dc;
        specular_color <= sc;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] nx, ny, nz, sx, sy, sz;
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        {start_x, start_y, start_z, end_x, end_y, end_z} = '0;
        {norm_x, norm_y, norm_z, line_width, diffuse_color, specular_color} = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain segment, zero direction, zero normal, parallel, extremes, tiny segments
        send_segment(0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 32'h0001_0000,
                     31'h0002_0000, 32'h1234_5678, 32'h9ABC_DEF0);
        send_segment(32'h0005_0000, 1, 2, 32'h0005_0000, 1, 2, 0, 32'h0001_0000, 0,
                     31'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        send_segment(0, 0, 0, 32'h0003_0000, 32'h0002_0000, 0, 0, 0, 0,
                     31'h0001_0000, 0, 32'hFFFF_FFFF);
        send_segment(0, 0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 0, 0,
                     31'h0001_0000, 1, 2);
        send_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                     31'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
        send_segment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                     31'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
        send_segment(32'h7FFF_0000, 0, 0, 32'h7FFF_0000, 32'h0001_0000, 0,
                     0, 0, 32'h0001_0000, 31'h0010_0000, 3, 4);
        send_segment(0, 0, 0, 1, 0, 0, 0, 1, 0, 31'h0, 5, 6);
        send_segment(0, 0, 0, 1, 1, 0, 0, 0, 1, 31'h1, 7, 8);

        // Random segments; a calm stretch in the middle
        for (int i = 0; i < 450; i++)
        begin
            calm = (i >= 150 && i < 230);
            sx = rand_coord(); sy = rand_coord(); sz = rand_coord();
            nx = rand_coord(); ny = rand_coord(); nz = rand_coord();
            if ($urandom_range(19) == 0)
                send_segment(sx, sy, sz, sx, sy, sz, nx, ny, nz,
                             31'($urandom), $urandom, $urandom);
            else if ($urandom_range(19) == 0)
                send_segment(sx, sy, sz, sx + nx, sy + ny, sz + nz, nx, ny, nz,
                             31'($urandom), $urandom, $urandom);
            else
                send_segment(sx, sy, sz, rand_coord(), rand_coord(), rand_coord(),
                             nx, ny, nz, ($urandom_range(3) == 0) ? 31'($urandom)
                             : 31'($urandom_range(32'h0010_0000)), $urandom, $urandom);
        end
        in_valid <= 1'b0;
        calm = 1'b0;

        // Drain, then allow the pipeline latency to flush any stray vertex
        while (pending_vertices != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule
